/* hdl/mlr_pkg.sv */
`timescale 1ns / 1ps

package mlr_pkg;

	// Request opcodes
	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_STEP = 1'b1
	} opcode_t;

	// Line direction flags produced by the setup logic
	typedef struct packed {
		logic x_is_major;
		logic minor_rises;
	} line_flags_t;

endpackage

/* hdl/midpoint_line_rasterizer_core.sv */
`timescale 1ns / 1ps
// Midpoint line rasterizer, all octants.
// A step request's pixel moves from the input register to the output register
// when the result register has room. Throughput: one request per cycle unless
// out_ready stalls it; the per-pixel update is one add and compare.
// Reset (arst_n low, asynchronous) clears the line state; the block starts idle.
module midpoint_line_rasterizer_core #(
	parameter int COORD_BITS = 9
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  opcode,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic                  last_pixel
);

	localparam int DW = COORD_BITS + 4;

	// input register
	logic                  valid_s1;
	logic                  opcode_s1;
	logic [COORD_BITS-1:0] start_x_s1, start_y_s1, end_x_s1, end_y_s1;

	// line state
	logic                  busy_q;
	mlr_pkg::line_flags_t  flags_q;
	logic [COORD_BITS-1:0] major_pos_q, minor_pos_q, major_stop_q;
	logic signed [DW-1:0]  decision_q, inc_neg_q, inc_nonneg_q;

	// result register
	logic                  out_valid_q;
	logic [COORD_BITS-1:0] pixel_x_q, pixel_y_q;
	logic                  last_pixel_q;

	// setup outputs
	mlr_pkg::line_flags_t  setup_flags;
	logic [COORD_BITS-1:0] setup_major_start, setup_minor_start, setup_major_end;
	logic signed [DW-1:0]  setup_decision, setup_inc_neg, setup_inc_nonneg;

	logic advance;
	logic is_load, is_step;
	logic last;

	// request moves on when the result register has room
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign is_load  = advance && (opcode_s1 == mlr_pkg::OP_LOAD);
	assign is_step  = advance && (opcode_s1 == mlr_pkg::OP_STEP) && busy_q;
	assign last     = (major_pos_q == major_stop_q);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			opcode_s1  <= opcode;
			start_x_s1 <= start_x;
			start_y_s1 <= start_y;
			end_x_s1   <= end_x;
			end_y_s1   <= end_y;
		end
	end

	mlr_setup #(
		.COORD_BITS (COORD_BITS)
	) u_setup (
		.start_x       (start_x_s1),
		.start_y       (start_y_s1),
		.end_x         (end_x_s1),
		.end_y         (end_y_s1),
		.flags         (setup_flags),
		.major_start   (setup_major_start),
		.minor_start   (setup_minor_start),
		.major_end     (setup_major_end),
		.decision_init (setup_decision),
		.inc_neg       (setup_inc_neg),
		.inc_nonneg    (setup_inc_nonneg)
	);

	// line state: load or one midpoint step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			flags_q      <= '0;
			major_pos_q  <= '0;
			minor_pos_q  <= '0;
			major_stop_q <= '0;
			decision_q   <= '0;
			inc_neg_q    <= '0;
			inc_nonneg_q <= '0;
		end else if (is_load) begin
			busy_q       <= 1'b1;
			flags_q      <= setup_flags;
			major_pos_q  <= setup_major_start;
			minor_pos_q  <= setup_minor_start;
			major_stop_q <= setup_major_end;
			decision_q   <= setup_decision;
			inc_neg_q    <= setup_inc_neg;
			inc_nonneg_q <= setup_inc_nonneg;
		end else if (is_step) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				major_pos_q <= major_pos_q + 1'b1;
				if (decision_q < 0) begin
					decision_q <= decision_q + inc_neg_q;
					if (flags_q.minor_rises) begin
						minor_pos_q <= minor_pos_q + 1'b1;
					end
				end else begin
					decision_q <= decision_q + inc_nonneg_q;
					if (!flags_q.minor_rises) begin
						minor_pos_q <= minor_pos_q - 1'b1;
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (is_step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_step) begin
			pixel_x_q    <= flags_q.x_is_major ? major_pos_q : minor_pos_q;
			pixel_y_q    <= flags_q.x_is_major ? minor_pos_q : major_pos_q;
			last_pixel_q <= last;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_x    = pixel_x_q;
	assign pixel_y    = pixel_y_q;
	assign last_pixel = last_pixel_q;

endmodule

/* hdl/mlr_setup.sv */
`timescale 1ns / 1ps

// Line setup: major axis choice, endpoint ordering, decision and increments.
module mlr_setup #(
	parameter int COORD_BITS = 9
) (
	input  logic [COORD_BITS-1:0]   start_x,
	input  logic [COORD_BITS-1:0]   start_y,
	input  logic [COORD_BITS-1:0]   end_x,
	input  logic [COORD_BITS-1:0]   end_y,
	output mlr_pkg::line_flags_t    flags,
	output logic [COORD_BITS-1:0]   major_start,
	output logic [COORD_BITS-1:0]   minor_start,
	output logic [COORD_BITS-1:0]   major_end,
	output logic signed [COORD_BITS+3:0] decision_init,
	output logic signed [COORD_BITS+3:0] inc_neg,
	output logic signed [COORD_BITS+3:0] inc_nonneg
);

	localparam int DW = COORD_BITS + 4;

	logic [COORD_BITS-1:0] dx, dy;
	logic                  x_major;
	logic [COORD_BITS-1:0] maj1, maj2, min1, min2;
	logic [COORD_BITS-1:0] omaj1, omaj2, omin1, omin2;
	logic                  rises;
	logic signed [DW-1:0]  a_w, b_w;

	// absolute spans
	assign dx = (end_x >= start_x) ? (end_x - start_x) : (start_x - end_x);
	assign dy = (end_y >= start_y) ? (end_y - start_y) : (start_y - end_y);
	assign x_major = (dx >= dy);

	// map to major/minor axes
	assign maj1 = x_major ? start_x : start_y;
	assign maj2 = x_major ? end_x   : end_y;
	assign min1 = x_major ? start_y : start_x;
	assign min2 = x_major ? end_y   : end_x;

	// order so the major coordinate rises; endpoints swap as a pair
	always_comb begin
		if (maj1 > maj2) begin
			omaj1 = maj2;
			omaj2 = maj1;
			omin1 = min2;
			omin2 = min1;
		end else begin
			omaj1 = maj1;
			omaj2 = maj2;
			omin1 = min1;
			omin2 = min2;
		end
	end

	assign rises = (omin2 >= omin1);

	// A = minor start - minor end, B = major span
	assign a_w = $signed({4'b0000, omin1}) - $signed({4'b0000, omin2});
	assign b_w = $signed({4'b0000, omaj2}) - $signed({4'b0000, omaj1});

	always_comb begin
		if (rises) begin
			decision_init = (a_w <<< 1) + b_w;
			inc_neg       = (a_w + b_w) <<< 1;
			inc_nonneg    = a_w <<< 1;
		end else begin
			decision_init = (a_w <<< 1) - b_w;
			inc_neg       = a_w <<< 1;
			inc_nonneg    = (a_w - b_w) <<< 1;
		end
	end

	assign flags.x_is_major  = x_major;
	assign flags.minor_rises = rises;
	assign major_start       = omaj1;
	assign minor_start       = omin1;
	assign major_end         = omaj2;

endmodule
